// ===== hw/rtl/elsp_pkg.sv =====
// Shared types, constants and the rating lookup for the export limit setpoint block.
// No dependencies; used by the top level and by the port checks.
package elsp_pkg;

    localparam int STATUS_RUN   = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_RATING_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_COUNT = 1'd1;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 24;

    // Scaled rating fits 23 bits (2^32 / 1000), a step only matters below 2^25.
    localparam int RATING_W = 23;
    localparam int MAG_W    = 32;
    localparam int STEP_W   = 25;
    localparam int PCT_W    = 16;

    // x / 1000 = (x * RECIP_1000) >> 38 for every 32-bit x.
    localparam logic [28:0] RECIP_1000 = 29'd274877907;
    localparam int          SHIFT_1000 = 38;
    // x / 10 = (x * RECIP_10) >> 19 for every 16-bit x.
    localparam logic [15:0] RECIP_10   = 16'd52429;
    localparam int          SHIFT_10   = 19;

    localparam int NUM_RATINGS = 17;
    localparam logic [15:0] RATE_CODE [NUM_RATINGS] = '{
        16'd101, 16'd102, 16'd103, 16'd104, 16'd105, 16'd106, 16'd107, 16'd108, 16'd109,
        16'd110, 16'd111, 16'd112, 16'd113, 16'd114, 16'd115, 16'd116, 16'd120
    };
    // Rated watts already divided by 100.
    localparam logic [8:0] RATE_HW [NUM_RATINGS] = '{
        9'd100, 9'd120, 9'd150, 9'd170, 9'd330, 9'd50, 9'd60, 9'd70, 9'd80,
        9'd360, 9'd200, 9'd250, 9'd300, 9'd280, 9'd400, 9'd330, 9'd500
    };
    localparam logic [8:0] RATE_DEFAULT = 9'd100;

    typedef struct packed {
        logic             mode;
        logic             enz;
        logic             go;
        logic             neg;
        logic [PCT_W-1:0] pct;
    } t_item;

    // Search the first n entries; the lowest matching entry wins.
    function automatic logic [8:0] rating_lookup(input logic [15:0] code, input int n);
        logic [8:0] r;
        r = RATE_DEFAULT;
        for (int k = NUM_RATINGS - 1; k >= 0; k--) begin
            if (k < n && code == RATE_CODE[k]) begin
                r = RATE_HW[k];
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/elsp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a saturating quotient.
// Depends on nothing but its parameters; used twice by the top level.
module elsp_div #(
    parameter int WN = 32,
    parameter int WD = 23,
    parameter int WQ = 25,
    parameter int WS = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [WN-1:0] i_num,
    input  logic [WD-1:0] i_den,
    input  logic [WS-1:0] i_side,
    output logic          o_valid,
    output logic [WQ-1:0] o_quo,
    output logic [WS-1:0] o_side
);

    logic          r_val  [WQ+1];
    logic          r_sat  [WQ+1];
    logic [WD-1:0] r_rem  [WQ+1];
    logic [WD-1:0] r_den  [WQ+1];
    logic [WQ-1:0] r_num  [WQ+1];
    logic [WQ-1:0] r_q    [WQ+1];
    logic [WS-1:0] r_side [WQ+1];

    logic [WN-1:0] n_top;
    assign n_top = i_num >> WQ;

    // Prep stage: split off the high part, flag a quotient too wide to hold.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val[0] <= 1'b0;
        end else if (i_en) begin
            r_val[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[0]  <= n_top >= WN'(i_den);
            r_rem[0]  <= WD'(n_top);
            r_den[0]  <= i_den;
            r_num[0]  <= WQ'(i_num);
            r_q[0]    <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < WQ; k++) begin : g_step
        logic [WD:0] n_trial;
        logic        n_bit;
        assign n_trial = {r_rem[k], r_num[k][WQ-1]};
        assign n_bit   = n_trial >= {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[k+1] <= 1'b0;
            end else if (i_en) begin
                r_val[k+1] <= r_val[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sat[k+1]  <= r_sat[k];
                r_rem[k+1]  <= n_bit ? WD'(n_trial - {1'b0, r_den[k]}) : WD'(n_trial);
                r_den[k+1]  <= r_den[k];
                r_num[k+1]  <= r_num[k] << 1;
                r_q[k+1]    <= WQ'({r_q[k], n_bit});
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_val[WQ];
    assign o_quo   = r_sat[WQ] ? '1 : r_q[WQ];
    assign o_side  = r_side[WQ];

endmodule

// ===== hw/rtl/export_limit_setpoint_step.sv =====
// Top level of the export limit setpoint block: input staging, scaling, two dividers, output.
// Depends on elsp_pkg and elsp_div.
//
// One readback/meter transaction in, one setpoint transaction out, one per clock
// when the output side keeps up. The path is 2 * (STEP_W + 1) + 2 = 54 register
// stages, most in the two divider pipelines that each resolve one quotient bit per
// stage: the first forms (|power| + rating/2) / rating, the second divides that
// step by the device count. The whole pipeline advances together and holds as a
// unit, bubbles included, while a result waits on the output register. Rating mode
// and device count come from the config port and must be written while no
// transaction is in flight. Scaling by 1000 and 10 is done by reciprocal multiply.
module export_limit_setpoint_step #(
    parameter int TABLE_ENTRIES = 17
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [elsp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [elsp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // status_word[15:0], enable_word[31:16], limit_raw[47:32],
    // rating_raw[79:48], grid_power[111:80]
    input  logic [elsp_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // adjust[0], write_enable[1], setpoint_value[17:2], zero pad[23:18]
    output logic [elsp_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import elsp_pkg::*;

    localparam int SIDE1_W = $bits(t_item);
    localparam int SIDE2_W = SIDE1_W + STEP_W;

    logic       r_rating_mode;
    logic [7:0] r_device_count;

    // Config writes land directly; out-of-list data bits are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rating_mode  <= 1'b0;
            r_device_count <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RATING_MODE:  r_rating_mode  <= i_cfg_data[0];
                CFG_DEVICE_COUNT: r_device_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [7:0] cnt_eff;
    assign cnt_eff = (r_device_count == 8'd0) ? 8'd1 : r_device_count;

    // Advance everything unless the output holds a result nobody has taken.
    logic r_out_valid;
    logic en;
    assign en              = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // Unpack the transaction.
    logic [15:0] in_status, in_enable, in_limit;
    logic [31:0] in_rating, in_power;
    assign in_status = i_s_axis_tdata[15:0];
    assign in_enable = i_s_axis_tdata[31:16];
    assign in_limit  = i_s_axis_tdata[47:32];
    assign in_rating = i_s_axis_tdata[79:48];
    assign in_power  = i_s_axis_tdata[111:80];

    // Stage 1: magnitude, table lookup, reciprocal products.
    logic             r_s1_valid;
    logic             r_s1_stat, r_s1_neg, r_s1_mode, r_s1_enz;
    logic [MAG_W-1:0] r_s1_mag;
    logic [8:0]       r_s1_tab;
    logic [60:0]      r_s1_prod_r;
    logic [31:0]      r_s1_prod_l;
    logic [15:0]      r_s1_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_stat   <= in_status == 16'(STATUS_RUN);
            r_s1_neg    <= in_power[31];
            // -2^31 wraps to itself, which is its magnitude as unsigned.
            r_s1_mag    <= in_power[31] ? (~in_power + 32'd1) : in_power;
            r_s1_mode   <= r_rating_mode;
            r_s1_enz    <= in_enable == 16'd0;
            r_s1_tab    <= rating_lookup(in_rating[15:0], TABLE_ENTRIES);
            r_s1_prod_r <= 61'(in_rating) * 61'(RECIP_1000);
            r_s1_prod_l <= 32'(in_limit) * 32'(RECIP_10);
            r_s1_limit  <= in_limit;
        end
    end

    // Stage 2 (feeds the first divider's prep register): rating, band, dividend.
    logic [RATING_W-1:0] rating, half;
    logic [PCT_W-1:0]    pct;
    logic [MAG_W-1:0]    dividend;
    t_item               item1;

    assign rating   = r_s1_mode ? RATING_W'(r_s1_tab) : r_s1_prod_r[SHIFT_1000 +: RATING_W];
    assign pct      = r_s1_mode ? r_s1_limit : PCT_W'(r_s1_prod_l[31:SHIFT_10]);
    assign half     = rating >> 1;
    assign dividend = r_s1_mag + MAG_W'(half);

    always_comb begin
        item1.mode = r_s1_mode;
        item1.enz  = r_s1_enz;
        item1.go   = r_s1_stat && (rating != '0) && (r_s1_mag > MAG_W'(half));
        item1.neg  = r_s1_neg;
        item1.pct  = pct;
    end

    logic               d1_valid;
    logic [STEP_W-1:0]  d1_quo;
    logic [SIDE1_W-1:0] d1_side;

    elsp_div #(
        .WN(MAG_W), .WD(RATING_W), .WQ(STEP_W), .WS(SIDE1_W)
    ) u_div_rating (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s1_valid),
        .i_num   (dividend),
        .i_den   (rating),
        .i_side  (item1),
        .o_valid (d1_valid),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    // Share the step across devices; the raw step rides along for the compare.
    logic               d2_valid;
    logic [STEP_W-1:0]  d2_quo;
    logic [SIDE2_W-1:0] d2_side;

    elsp_div #(
        .WN(STEP_W), .WD(8), .WQ(STEP_W), .WS(SIDE2_W)
    ) u_div_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d1_valid),
        .i_num   (d1_quo),
        .i_den   (cnt_eff),
        .i_side  ({d1_side, d1_quo}),
        .o_valid (d2_valid),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    // Final stage: pick the step, move the limit, clamp.
    t_item             item2;
    logic [STEP_W-1:0] step_raw, step;
    logic [STEP_W:0]   sum;
    logic [PCT_W-1:0]  val, setpoint;

    assign item2    = t_item'(d2_side[SIDE2_W-1:STEP_W]);
    assign step_raw = d2_side[STEP_W-1:0];
    assign step     = (step_raw > STEP_W'(cnt_eff)) ? d2_quo : step_raw;
    assign sum      = (STEP_W+1)'(item2.pct) + (STEP_W+1)'(step);

    always_comb begin
        val = '0;
        if (item2.go && step != '0) begin
            if (item2.neg) begin
                if (item2.pct > PCT_W'(1)) begin
                    val = ((STEP_W+1)'(item2.pct) > (STEP_W+1)'(step))
                        ? PCT_W'((STEP_W+1)'(item2.pct) - (STEP_W+1)'(step))
                        : PCT_W'(1);
                end
            end else if (item2.pct < PCT_W'(100)) begin
                val = (sum > (STEP_W+1)'(100)) ? PCT_W'(100) : PCT_W'(sum);
            end
        end
    end

    assign setpoint = item2.mode ? val : PCT_W'(20'(val) * 20'd10);

    logic [OUT_DATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= {6'd0,
                           (val != '0) ? setpoint : PCT_W'(0),
                           (val != '0) && item2.enz,
                           val != '0};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== hw/rtl/elsp_chk.sv =====
// Port-level checks for the export limit setpoint block, bound to its top level.
// Depends on elsp_pkg for port widths.
module elsp_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [elsp_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // Write enable only comes with an adjustment.
    a_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1] |-> o_m_axis_tdata[0])
        else $error("write_enable without adjust");

    // No adjustment means a zero setpoint; an adjustment a nonzero one.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[0] == (o_m_axis_tdata[17:2] != 16'd0)))
        else $error("setpoint does not match adjust");

    // Input is taken whenever the output side is free.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind export_limit_setpoint_step elsp_chk u_elsp_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
